FILE: hw/rtl/rf_packet_crc_checksum_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet CRC and checksum block
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RF_PACKET_CRC_CHECKSUM_ASSERT_SVH
`define RF_PACKET_CRC_CHECKSUM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RPCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpcc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define RPCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcc: next-cycle check failed");

`endif

FILE: hw/rtl/rpcc_pkg.sv
// ---------------------------------------------------------------------------
// rpcc_pkg
// Beat types, framing constants and the nibble table of the packet CRC.
// ---------------------------------------------------------------------------
package rpcc_pkg;

    localparam int unsigned POS_W = 5;

    localparam int unsigned        EXT_FLAG_BIT = 4;
    localparam logic [POS_W-1:0]   LAST_EXT     = 5'd22;  // 23-byte packet
    localparam logic [POS_W-1:0]   LAST_STD     = 5'd8;   // 9-byte packet
    localparam logic [POS_W-1:0]   SUM_FIRST    = 5'd7;
    localparam logic [POS_W-1:0]   SUM_LAST     = 5'd21;

    typedef struct packed {
        logic [7:0] pkt_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [7:0] rf_crc;
        logic [7:0] ext_checksum;
        logic       is_extended;
    } result_beat_t;

    function automatic logic [7:0] nib_tab(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'h0:    val = 8'h00;
            4'h1:    val = 8'h30;
            4'h2:    val = 8'h60;
            4'h3:    val = 8'h50;
            4'h4:    val = 8'hC0;
            4'h5:    val = 8'hF0;
            4'h6:    val = 8'hA0;
            4'h7:    val = 8'h90;
            4'h8:    val = 8'h80;
            4'h9:    val = 8'hB0;
            4'hA:    val = 8'hE0;
            4'hB:    val = 8'hD0;
            4'hC:    val = 8'h40;
            4'hD:    val = 8'h70;
            4'hE:    val = 8'h20;
            4'hF:    val = 8'h10;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/rpcc_stream_if.sv
// ---------------------------------------------------------------------------
// rpcc_stream_if
// Valid/ready stream channel carrying one beat of a packed payload type.
// ---------------------------------------------------------------------------
interface rpcc_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rpcc_pipe_reg.sv
// ---------------------------------------------------------------------------
// rpcc_pipe_reg
// One-deep pipeline register on a valid/ready stream; full throughput.
// ---------------------------------------------------------------------------
module rpcc_pipe_reg (
    input  logic          clk,
    input  logic          rst_n,
    rpcc_stream_if.sink   up,
    rpcc_stream_if.source down
);

    logic valid_reg;
    logic valid_next;

    // Take a new beat whenever the register is empty or is being drained
    assign up.ready   = !valid_reg || down.ready;
    assign valid_next = up.ready ? up.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            down.data <= up.data;
        end
    end

    assign down.valid = valid_reg;

endmodule

FILE: hw/rtl/rpcc_update.sv
// ---------------------------------------------------------------------------
// rpcc_update
// Per-byte framing, CRC and checksum update; emits one result per packet.
// ---------------------------------------------------------------------------
`include "rf_packet_crc_checksum_assert.svh"

module rpcc_update (
    input  logic          clk,
    input  logic          rst_n,
    rpcc_stream_if.sink   byte_in,
    rpcc_stream_if.source res_out
);

    logic [rpcc_pkg::POS_W-1:0] pos_reg;
    logic [rpcc_pkg::POS_W-1:0] pos_next;
    logic [7:0]                 crc_reg;
    logic [7:0]                 crc_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic                       ext_reg;
    logic                       ext_next;

    logic [7:0]                 b;
    logic [7:0]                 crc_mix;
    logic [7:0]                 crc_new;
    logic [rpcc_pkg::POS_W-1:0] last_pos;
    logic                       in_sum;
    logic                       is_last;
    logic                       fire;

    assign b    = byte_in.data.pkt_byte;
    assign fire = byte_in.valid && res_out.ready;

    always_comb
    begin
        // Length flag is sampled only from the first byte of a packet
        ext_next = (pos_reg == '0) ? b[rpcc_pkg::EXT_FLAG_BIT] : ext_reg;

        crc_mix  = crc_reg ^ b;
        crc_new  = crc_mix ^ rpcc_pkg::nib_tab(crc_mix[3:0]);

        in_sum   = ext_next && (pos_reg inside {[rpcc_pkg::SUM_FIRST:rpcc_pkg::SUM_LAST]});
        last_pos = ext_next ? rpcc_pkg::LAST_EXT : rpcc_pkg::LAST_STD;
        is_last  = (pos_reg >= last_pos);

        if (is_last)
        begin
            pos_next = '0;
            crc_next = '0;
            sum_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            crc_next = crc_new;
            sum_next = in_sum ? (sum_reg + b) : sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            sum_reg <= '0;
            ext_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            sum_reg <= sum_next;
            ext_reg <= ext_next;
        end
    end

    // Hold the byte while the result register is full and not being drained
    assign byte_in.ready             = res_out.ready;
    assign res_out.valid             = byte_in.valid && is_last;
    assign res_out.data.rf_crc       = crc_new;
    assign res_out.data.ext_checksum = ext_next ? (8'd0 - sum_reg) : 8'd0;
    assign res_out.data.is_extended  = ext_next;

    `RPCC_ASSERT_SAME(a_pos_range, 1'b1, pos_reg <= rpcc_pkg::LAST_EXT)
    `RPCC_ASSERT_SAME(a_start_clean, pos_reg == '0, (crc_reg == '0) && (sum_reg == '0))
    `RPCC_ASSERT_SAME(a_std_no_sum, !ext_reg && (pos_reg != '0), sum_reg == '0)
    `RPCC_ASSERT_NEXT(a_wrap_after_last, fire && is_last, pos_reg == '0)

endmodule

FILE: hw/rtl/rf_packet_crc_checksum.sv
// ---------------------------------------------------------------------------
// rf_packet_crc_checksum
// Frames radio packets from a byte stream and reports CRC and checksum.
// ---------------------------------------------------------------------------
//  channel  dir  payload                               beat
//  pkt      in   pkt_byte[7:0]                         one packet byte
//  res      out  rf_crc[7:0] ext_checksum[7:0]         one per packet,
//                is_extended                           after its last byte
//
//  Accepts one byte per cycle unless the result register stalls; a result
//  passes the input register, then the result register, after the packet's last byte.
//  The per-byte CRC table lookup and sum update sit between those registers.
//  Reset clears the framing position, CRC, sum and length flag.
//  A stalled result register holds the byte in the input register and
//  then deasserts pkt.ready.
// ---------------------------------------------------------------------------
module rf_packet_crc_checksum (
    input  logic          clk,
    input  logic          rst_n,
    rpcc_stream_if.sink   pkt,
    rpcc_stream_if.source res
);

    rpcc_stream_if #(.payload_t(rpcc_pkg::byte_beat_t))   byte_q ();
    rpcc_stream_if #(.payload_t(rpcc_pkg::result_beat_t)) res_d ();

    rpcc_pipe_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (pkt),
        .down  (byte_q)
    );

    rpcc_update u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_q),
        .res_out (res_d)
    );

    rpcc_pipe_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (res_d),
        .down  (res)
    );

endmodule

FILE: tb/rf_packet_crc_checksum_check.sv
// ---------------------------------------------------------------------------
// Packet CRC and checksum checker
// Watches the byte and result channels of the block, frames packets on its
// own, works out CRC, checksum and length flag for each packet, and compares
// every result beat with the oldest expected one.
// ---------------------------------------------------------------------------
module rf_packet_crc_checksum_check (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pkt_valid,
    input  logic                   pkt_ready,
    input  rpcc_pkg::byte_beat_t   pkt_data,
    input  logic                   res_valid,
    input  logic                   res_ready,
    input  rpcc_pkg::result_beat_t res_data,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Nibble table, entry 0 in the low byte
    localparam logic [127:0] CRC_NIBBLE = {
        8'h10, 8'h20, 8'h70, 8'h40, 8'hD0, 8'hE0, 8'hB0, 8'h80,
        8'h90, 8'hA0, 8'hF0, 8'hC0, 8'h50, 8'h60, 8'h30, 8'h00
    };

    logic [rpcc_pkg::POS_W-1:0] frame_pos;
    logic [7:0]                 crc_run;
    logic [7:0]                 sum_run;
    logic                       long_pkt;

    rpcc_pkg::result_beat_t     packet_results[$];

    // Advance the framing state by one byte; return 1 when the packet closes
    function automatic bit absorb_byte(input logic [7:0] b,
                                       output rpcc_pkg::result_beat_t r);
        logic [7:0]                 c;
        logic [rpcc_pkg::POS_W-1:0] last_pos;
        if (frame_pos == '0)
            long_pkt = b[rpcc_pkg::EXT_FLAG_BIT];
        c = crc_run ^ b;
        c = c ^ CRC_NIBBLE[c[3:0]*8 +: 8];
        crc_run = c;
        if (long_pkt && frame_pos >= rpcc_pkg::SUM_FIRST && frame_pos <= rpcc_pkg::SUM_LAST)
            sum_run = sum_run + b;
        last_pos = long_pkt ? rpcc_pkg::LAST_EXT : rpcc_pkg::LAST_STD;
        r = '0;
        if (frame_pos >= last_pos)
        begin
            r.rf_crc       = c;
            r.ext_checksum = long_pkt ? 8'(-sum_run) : 8'h00;
            r.is_extended  = long_pkt;
            frame_pos = '0;
            crc_run   = '0;
            sum_run   = '0;
            return 1'b1;
        end
        frame_pos = frame_pos + 1'b1;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rpcc_pkg::result_beat_t want;
        rpcc_pkg::result_beat_t fresh;
        if (!rst_n)
        begin
            frame_pos = '0;
            crc_run   = '0;
            sum_run   = '0;
            long_pkt  = 1'b0;
            errors    = 0;
            packet_results.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (packet_results.size() == 0)
                begin
                    $error("unexpected result beat: rf_crc %02h ext_checksum %02h is_extended %0b",
                           res_data.rf_crc, res_data.ext_checksum, res_data.is_extended);
                    errors++;
                end
                else
                begin
                    want = packet_results.pop_front();
                    if (res_data.rf_crc !== want.rf_crc)
                    begin
                        $error("rf_crc: expected %02h, actual %02h",
                               want.rf_crc, res_data.rf_crc);
                        errors++;
                    end
                    if (res_data.ext_checksum !== want.ext_checksum)
                    begin
                        $error("ext_checksum: expected %02h, actual %02h",
                               want.ext_checksum, res_data.ext_checksum);
                        errors++;
                    end
                    if (res_data.is_extended !== want.is_extended)
                    begin
                        $error("is_extended: expected %0b, actual %0b",
                               want.is_extended, res_data.is_extended);
                        errors++;
                    end
                end
            end
            if (pkt_valid && pkt_ready)
            begin
                if (absorb_byte(pkt_data.pkt_byte, fresh))
                    packet_results.push_back(fresh);
            end
        end
        pending = packet_results.size();
    end

endmodule

FILE: tb/tb_rf_packet_crc_checksum.sv
// ---------------------------------------------------------------------------
// Packet CRC and checksum testbench
// Streams directed and random packets of both lengths into the block under
// several sender and receiver idling mixes, including one long receiver
// hold-off, and leaves prediction and comparison to the checker.
// ---------------------------------------------------------------------------
module tb_rf_packet_crc_checksum;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTES_PHASE  = 200;
    localparam int HOLD_CYCLES  = 250;

    logic clk;
    logic rst_n;

    int   idle_pct;
    int   stall_pct;
    bit   hold_req;
    int   cycles;
    int   errors;
    int   pending;

    rpcc_stream_if #(.payload_t(rpcc_pkg::byte_beat_t))   pkt_if ();
    rpcc_stream_if #(.payload_t(rpcc_pkg::result_beat_t)) res_if ();

    rf_packet_crc_checksum dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if.sink),
        .res   (res_if.source)
    );

    rf_packet_crc_checksum_check crc_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_if.valid),
        .pkt_ready (pkt_if.ready),
        .pkt_data  (pkt_if.data),
        .res_valid (res_if.valid),
        .res_ready (res_if.ready),
        .res_data  (res_if.data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte, idling first at the current rate; return on its accept edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid         <= 1'b1;
        pkt_if.data.pkt_byte <= b;
        do
            @(posedge clk);
        while (!pkt_if.ready);
    endtask

    task automatic send_random_packet(inout int sent);
        logic [7:0] head;
        int         len;
        head = 8'($urandom_range(255));
        len  = head[rpcc_pkg::EXT_FLAG_BIT] ? int'(rpcc_pkg::LAST_EXT) + 1
                                             : int'(rpcc_pkg::LAST_STD) + 1;
        send_byte(head);
        for (int i = 1; i < len; i++)
            send_byte(8'($urandom_range(255)));
        sent += len;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("rf_packet_crc_checksum test failed");
        $finish;
    end

    initial
    begin
        int sent;
        int idle_mix  [4];
        int stall_mix [4];
        idle_mix  = '{0, 78, 0, 6};
        stall_mix = '{0, 0, 78, 6};
        sent      = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        rst_n                <= 1'b0;
        pkt_if.valid         <= 1'b0;
        pkt_if.data.pkt_byte <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Standard packet: flag clear in the head, bit 4 set in every later byte
        send_byte(8'hEF);
        repeat (8) send_byte(8'hFF);
        // Extended packet: zeros before the summed span, all ones inside it
        send_byte(8'h10);
        repeat (6) send_byte(8'h00);
        repeat (15) send_byte(8'hFF);
        send_byte(8'h80);
        // Extended packet of all ones, standard packet of all zeros
        repeat (23) send_byte(8'hFF);
        repeat (9) send_byte(8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            int phase_end;
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            phase_end = sent + BYTES_PHASE;
            while (sent < phase_end)
            begin
                // Starve the output mid-phase while bytes keep coming
                if (ph == 0 && sent >= BYTES_PHASE / 2 && sent < BYTES_PHASE / 2 + 23)
                    hold_req = 1'b1;
                send_random_packet(sent);
            end
        end

        pkt_if.valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("rf_packet_crc_checksum test passed");
        else
            $display("rf_packet_crc_checksum test failed");
        $finish;
    end

endmodule
